/* sv/sapg_pkg.sv */
// Shared types and constants for the stepper angle pulse generator.
package sapg_pkg;

  localparam int ANGLE_BITS = 24;
  localparam int MV_W       = ANGLE_BITS + 1;
  localparam int PPD_W      = 16;
  localparam int HALF_W     = 16;
  localparam int STEP_W     = 28;
  localparam int FRAC_BITS  = 12;
  localparam int PROD_W     = MV_W + PPD_W;
  // Sum keeps at least one bit above the saturated count.
  localparam int SUM_W      = (PROD_W + 1 > FRAC_BITS + STEP_W + 1) ?
                              PROD_W + 1 : FRAC_BITS + STEP_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_ZERO = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ABS_MODE  = 2'd0,
    REG_PPD       = 2'd1,
    REG_CW_LEVEL  = 2'd2,
    REG_HALF_TICK = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              abs_mode;
    logic [PPD_W-1:0]  pulses_per_degree;
    logic              cw_level;
    logic [HALF_W-1:0] half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic              nonzero;
    logic              negative;
  } move_t;

  typedef struct packed {
    logic              dir_level;
    logic              step_level;
    logic              busy_res;
    logic              rejected;
    logic [STEP_W-1:0] steps_left;
  } res_t;

endpackage

/* sv/sapg_if.sv */
// Command and result channel interfaces.
interface sapg_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             kind;
  logic signed [sapg_pkg::ANGLE_BITS-1:0] angle;

  modport source (output valid, output kind, output angle, input ready);
  modport sink   (input valid, input kind, input angle, output ready);
endinterface

interface sapg_res_if;
  logic                            valid;
  logic                            ready;
  logic                            dir_level;
  logic                            step_level;
  logic                            busy_res;
  logic                            rejected;
  logic [sapg_pkg::STEP_W-1:0]     steps_left;

  modport source (output valid, output dir_level, output step_level, output busy_res,
                  output rejected, output steps_left, input ready);
  modport sink   (input valid, input dir_level, input step_level, input busy_res,
                  input rejected, input steps_left, output ready);
endinterface

/* sv/sapg_step_count.sv */
// Move computation: signed move, rounded step count with saturation.
module sapg_step_count (
  input  logic signed [sapg_pkg::ANGLE_BITS-1:0] angle,
  input  logic signed [sapg_pkg::ANGLE_BITS-1:0] tracked,
  input  logic                                   abs_mode,
  input  logic [sapg_pkg::PPD_W-1:0]             pulses_per_degree,
  output sapg_pkg::move_t                        move
);
  import sapg_pkg::*;

  logic signed [MV_W-1:0] mv;
  logic [MV_W-1:0]        mv_neg;
  logic [MV_W-1:0]        mag;
  logic [PROD_W-1:0]      prod;
  logic [SUM_W-1:0]       sum;
  logic                   sat;

  always_comb begin
    if (abs_mode) begin
      mv = MV_W'(angle) - MV_W'(tracked);
    end else begin
      mv = MV_W'(angle);
    end
    mv_neg = -mv;
    mag    = mv[MV_W-1] ? mv_neg : mv;
    prod   = PROD_W'(mag) * PROD_W'(pulses_per_degree);
    // round half up, then drop the 4+8 fraction bits
    sum    = SUM_W'(prod) + SUM_W'(1 << (FRAC_BITS - 1));
    sat    = |sum[SUM_W-1:FRAC_BITS+STEP_W];
    move.steps    = sat ? STEP_MAX : sum[FRAC_BITS+STEP_W-1:FRAC_BITS];
    move.nonzero  = |mv;
    move.negative = mv[MV_W-1];
  end

endmodule

/* sv/sapg_engine.sv */
// Position, pulse and direction state; applies one item per advance.
module sapg_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  logic [1:0]                             kind,
  input  logic signed [sapg_pkg::ANGLE_BITS-1:0] angle,
  input  sapg_pkg::cfg_t                         cfg,
  output sapg_pkg::res_t                         res
);
  import sapg_pkg::*;

  logic signed [ANGLE_BITS-1:0] tracked, tracked_next;
  logic [STEP_W-1:0]            pending, pending_next;
  logic [HALF_W-1:0]            phase, phase_next;
  logic                         step_pin, step_pin_next;
  logic                         dir_pin, dir_pin_next;
  logic [HALF_W:0]              phase_inc;
  logic                         rejected;
  move_t                        move;

  sapg_step_count u_count (
    .angle             (angle),
    .tracked           (tracked),
    .abs_mode          (cfg.abs_mode),
    .pulses_per_degree (cfg.pulses_per_degree),
    .move              (move)
  );

  always_comb begin
    tracked_next  = tracked;
    pending_next  = pending;
    phase_next    = phase;
    step_pin_next = step_pin;
    dir_pin_next  = dir_pin;
    rejected      = 1'b0;
    phase_inc     = {1'b0, phase} + (HALF_W+1)'(1);
    case (kind_t'(kind))
      KIND_TICK: begin
        if (pending != '0) begin
          if (phase_inc < {1'b0, cfg.half_period_ticks}) begin
            phase_next = phase_inc[HALF_W-1:0];
          end else begin
            phase_next = '0;
            if (step_pin) begin
              step_pin_next = 1'b0;
            end else begin
              // end of low phase: one step done
              pending_next  = pending - STEP_W'(1);
              step_pin_next = (pending != STEP_W'(1));
            end
          end
        end
      end
      KIND_CMD: begin
        if (pending != '0) begin
          rejected = 1'b1;
        end else begin
          if (move.nonzero) begin
            dir_pin_next = cfg.cw_level ^ move.negative;
          end
          if (cfg.abs_mode) begin
            tracked_next = angle;
          end
          pending_next  = move.steps;
          phase_next    = '0;
          step_pin_next = |move.steps;
        end
      end
      KIND_ZERO: begin
        tracked_next = '0;
      end
      default: begin
      end
    endcase

    res.dir_level  = dir_pin_next;
    res.step_level = step_pin_next;
    res.busy_res   = |pending_next;
    res.rejected   = rejected;
    res.steps_left = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked  <= '0;
      pending  <= '0;
      phase    <= '0;
      step_pin <= 1'b0;
      dir_pin  <= 1'b0;
    end else if (advance) begin
      tracked  <= tracked_next;
      pending  <= pending_next;
      phase    <= phase_next;
      step_pin <= step_pin_next;
      dir_pin  <= dir_pin_next;
    end
  end

endmodule

/* sv/stepper_angle_pulse_generator_unit.sv */
// Top level: config registers, input register, engine and result register.
//
//   channel  dir  payload                                              transfer
//   cmd      in   kind, angle                                          valid & ready
//   res      out  dir_level, step_level, busy_res, rejected, steps_left valid & ready
//   cfg      in   cfg_index, cfg_data                                  cfg_wr_en
//
// One item per clock while the result is not stalled: an item is held in the input register,
// is applied to the state by the engine's combinational step-count path (one 25x16 multiply)
// and lands in the result register.
// Synchronous reset restores the default registers, clears the engine state and both valid flags.
// A stalled result holds the result register; an empty input register still takes
// one more item, then cmd.ready drops until the result moves on.
module stepper_angle_pulse_generator_unit (
  input  logic                                clk,
  input  logic                                rst,
  sapg_cmd_if.sink                            cmd,
  sapg_res_if.source                          res,
  input  logic                                cfg_wr_en,
  input  logic [sapg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sapg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sapg_pkg::*;

  cfg_t                         cfg;
  logic                         in_valid;
  logic [1:0]                   in_kind;
  logic signed [ANGLE_BITS-1:0] in_angle;
  logic                         out_valid;
  res_t                         out_res;
  res_t                         eng_res;
  logic                         advance;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.abs_mode          <= 1'b1;
      cfg.pulses_per_degree <= PPD_W'(256);
      cfg.cw_level          <= 1'b1;
      cfg.half_period_ticks <= HALF_W'(1000);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ABS_MODE:  cfg.abs_mode          <= cfg_data[0];
        REG_PPD:       cfg.pulses_per_degree <= cfg_data[PPD_W-1:0];
        REG_CW_LEVEL:  cfg.cw_level          <= cfg_data[0];
        REG_HALF_TICK: cfg.half_period_ticks <= cfg_data[HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_kind  <= cmd.kind;
      in_angle <= cmd.angle;
    end
  end

  sapg_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .kind    (in_kind),
    .angle   (in_angle),
    .cfg     (cfg),
    .res     (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= eng_res;
    end
  end

  assign res.valid      = out_valid;
  assign res.dir_level  = out_res.dir_level;
  assign res.step_level = out_res.step_level;
  assign res.busy_res   = out_res.busy_res;
  assign res.rejected   = out_res.rejected;
  assign res.steps_left = out_res.steps_left;

endmodule

/* tb/sv/stepper_angle_pulse_generator_unit_tb.sv */
// Self-checking testbench for the stepper angle pulse generator: predicted status vs DUT results.
`timescale 1ns / 1ps

module stepper_angle_pulse_generator_unit_tb;
  import sapg_pkg::*;

  localparam int LIMIT       = 500000;
  localparam int WANT_ITEMS  = 1850;
  localparam int ANGLE_MIN   = -(1 << (ANGLE_BITS - 1));
  localparam int ANGLE_MAX   = (1 << (ANGLE_BITS - 1)) - 1;
  // Largest random move keeps a command at a handful of steps.
  localparam int MOVE_BUDGET = 24576;

  // Tracks the block's position/pulse state and holds the expected status per transfer.
  class pulse_scoreboard;
    logic                          abs_mode;
    logic [PPD_W-1:0]              ppd;
    logic                          cw;
    logic [HALF_W-1:0]             half;
    logic signed [ANGLE_BITS-1:0]  position;
    logic [STEP_W-1:0]             steps_left;
    logic [HALF_W-1:0]             phase_cnt;
    logic                          step_pin;
    logic                          dir_pin;
    res_t                          status_q[$];
    int                            errors;

    function new();
      abs_mode   = 1'b1;
      ppd        = 16'd256;
      cw         = 1'b1;
      half       = 16'd1000;
      position   = '0;
      steps_left = '0;
      phase_cnt  = '0;
      step_pin   = 1'b0;
      dir_pin    = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ABS_MODE:  abs_mode = data[0];
        REG_PPD:       ppd      = data[PPD_W-1:0];
        REG_CW_LEVEL:  cw       = data[0];
        REG_HALF_TICK: half     = data[HALF_W-1:0];
        default: ;
      endcase
    endfunction

    // round(|move| * ppd / 4096), half up, saturated
    function logic [STEP_W-1:0] step_count(logic [MV_W-1:0] mag);
      logic [SUM_W-1:0] sum;
      sum = (SUM_W'(mag) * SUM_W'(ppd) + SUM_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (sum > SUM_W'(STEP_MAX))
        return STEP_MAX;
      return sum[STEP_W-1:0];
    endfunction

    function void start_move(logic signed [ANGLE_BITS-1:0] target);
      logic signed [MV_W-1:0] mv;
      logic [MV_W-1:0]        mag;
      logic [STEP_W-1:0]      cnt;
      mv  = abs_mode ? MV_W'(target) - MV_W'(position) : MV_W'(target);
      mag = mv[MV_W-1] ? -mv : mv;
      cnt = step_count(mag);
      if (mv > 0)
        dir_pin = cw;
      else if (mv < 0)
        dir_pin = ~cw;
      if (abs_mode)
        position = target;
      steps_left = cnt;
      phase_cnt  = '0;
      step_pin   = (cnt != 0);
    endfunction

    function void advance_tick();
      if (steps_left == 0)
        return;
      phase_cnt++;
      if (phase_cnt < half)
        return;
      phase_cnt = '0;
      if (step_pin) begin
        step_pin = 1'b0;
      end else begin
        steps_left--;
        step_pin = (steps_left != 0);
      end
    endfunction

    function void note_item(kind_t k, logic signed [ANGLE_BITS-1:0] a);
      res_t r;
      logic rej;
      rej = 1'b0;
      case (k)
        KIND_TICK: advance_tick();
        KIND_CMD: begin
          if (steps_left != 0)
            rej = 1'b1;
          else
            start_move(a);
        end
        KIND_ZERO: position = '0;
        default: ;
      endcase
      r.dir_level  = dir_pin;
      r.step_level = step_pin;
      r.busy_res   = (steps_left != 0);
      r.rejected   = rej;
      r.steps_left = steps_left;
      status_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (status_q.size() == 0) begin
        report("result transfer with no status expected");
        return;
      end
      want = status_q.pop_front();
      if (got.dir_level !== want.dir_level)
        report($sformatf("dir_level got %b want %b", got.dir_level, want.dir_level));
      if (got.step_level !== want.step_level)
        report($sformatf("step_level got %b want %b", got.step_level, want.step_level));
      if (got.busy_res !== want.busy_res)
        report($sformatf("busy_res got %b want %b", got.busy_res, want.busy_res));
      if (got.rejected !== want.rejected)
        report($sformatf("rejected got %b want %b", got.rejected, want.rejected));
      if (got.steps_left !== want.steps_left)
        report($sformatf("steps_left got %0d want %0d", got.steps_left, want.steps_left));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sapg_cmd_if cmd_ch ();
  sapg_res_if res_ch ();

  stepper_angle_pulse_generator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pulse_scoreboard sb;
  int cycles;
  int counted;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(kind_t k, int ang);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind  <= k;
    cmd_ch.angle <= ANGLE_BITS'(ang);
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_item(k, ANGLE_BITS'(ang));
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(negedge clk);
    sb.set_reg(idx, CFG_DATA_W'(data));
  endtask

  task automatic set_regs(bit abs_m, int ppd, bit cw, int half);
    drain();
    write_reg(REG_ABS_MODE, abs_m);
    write_reg(REG_PPD, ppd);
    write_reg(REG_CW_LEVEL, cw);
    write_reg(REG_HALF_TICK, half);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly small well-formed moves followed by ticks; noise is stray kinds,
  // zero requests and commands that land while busy.
  task automatic random_phase(int n);
    bit    abs_m;
    bit    busy;
    int    ppd;
    int    half;
    int    sel;
    int    r;
    int    mag;
    int    tgt;
    int    ang;
    kind_t k;
    abs_m = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    if (sel == 0)
      ppd = 0;
    else if (sel == 1)
      ppd = $urandom_range(1024, 65535);
    else
      ppd = $urandom_range(1, 1023);
    sel = $urandom_range(0, 9);
    if (sel < 6)
      half = $urandom_range(0, 3);
    else if (sel < 9)
      half = $urandom_range(4, 12);
    else
      half = $urandom_range(13, 40);
    set_regs(abs_m, ppd, 1'($urandom_range(0, 1)), half);
    calm = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      busy = (sb.steps_left != 0);
      r    = $urandom_range(0, 99);
      ang  = int'($urandom);
      if (busy)
        k = (r < 3) ? KIND_NONE : (r < 7) ? KIND_ZERO : (r < 15) ? KIND_CMD : KIND_TICK;
      else
        k = (r < 4) ? KIND_NONE : (r < 8) ? KIND_ZERO : (r < 20) ? KIND_TICK : KIND_CMD;
      if (!busy && k == KIND_CMD && ppd != 0) begin
        mag = $urandom_range(0, MOVE_BUDGET / ppd);
        if ($urandom_range(0, 1))
          mag = -mag;
        tgt = abs_m ? int'(sb.position) + mag : mag;
        if (tgt > ANGLE_MAX)
          tgt = ANGLE_MAX;
        if (tgt < ANGLE_MIN)
          tgt = ANGLE_MIN;
        ang = tgt;
      end
      if (k == KIND_CMD || k == KIND_ZERO || (k == KIND_TICK && busy))
        counted++;
      send_item(k, ang);
    end
    calm = 1'b0;
  endtask

  // Result side: random stalls, sample at the rising edge, compare.
  initial begin
    res_t got;
    int   gap;
    res_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.dir_level  = res_ch.dir_level;
      got.step_level = res_ch.step_level;
      got.busy_res   = res_ch.busy_res;
      got.rejected   = res_ch.rejected;
      got.steps_left = res_ch.steps_left;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  initial begin
    sb           = new();
    counted      = 0;
    calm         = 1'b0;
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.kind  = KIND_TICK;
    cmd_ch.angle = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_ABS_MODE;
    cfg_data     = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: absolute, 1 step per degree, cw high, long half period
    send_item(KIND_NONE, -1);
    send_item(KIND_TICK, 0);
    send_item(KIND_ZERO, 5);
    send_item(KIND_CMD, 0);      // zero move keeps direction
    send_item(KIND_CMD, 7);      // rounds down to no steps, direction still set
    send_item(KIND_CMD, 0);
    send_item(KIND_CMD, 8);      // exactly half a step rounds up
    send_item(KIND_TICK, 0);
    send_item(KIND_TICK, 0);
    send_item(KIND_CMD, -100);   // busy, so rejected
    send_item(KIND_ZERO, 0);     // position cleared mid-pulse
    send_item(KIND_NONE, 0);

    // half period of zero finishes the running pulse; zero ppd gives no steps
    set_regs(1'b0, 0, 1'b0, 0);
    send_item(KIND_TICK, 0);
    send_item(KIND_TICK, 0);
    send_item(KIND_CMD, ANGLE_MAX);
    send_item(KIND_CMD, ANGLE_MIN);

    set_regs(1'b1, 0, 1'b1, 1);
    send_item(KIND_CMD, ANGLE_MIN);
    send_item(KIND_CMD, ANGLE_MAX);  // largest absolute move
    send_item(KIND_ZERO, 0);

    set_regs(1'b0, 65535, 1'b1, 65535);
    send_item(KIND_CMD, -1);
    repeat (3) send_item(KIND_TICK, 0);

    while (counted < WANT_ITEMS)
      random_phase($urandom_range(80, 200));

    // finish any running move, then the largest relative step count
    set_regs(1'b0, 65535, 1'b0, 0);
    while (sb.steps_left != 0)
      send_item(KIND_TICK, 0);
    send_item(KIND_CMD, ANGLE_MIN);
    repeat (3) send_item(KIND_TICK, 0);
    send_item(KIND_CMD, 5);
    drain();

    if (sb.status_q.size() != 0)
      sb.report("status expectations left over");
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* stepper_angle_pulse_generator_unit.f */
sv/sapg_pkg.sv
sv/sapg_if.sv
sv/sapg_step_count.sv
sv/sapg_engine.sv
sv/stepper_angle_pulse_generator_unit.sv
tb/sv/stepper_angle_pulse_generator_unit_tb.sv
